FILE: src/assert_macros.svh
// Assertion helpers for the extent table walker checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ETBW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define ETBW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/etbw_pkg.sv
`default_nettype none
package etbw_pkg;

  localparam int DEF_MAX_CHAINS  = 4;
  localparam int DEF_MAX_EXTENTS = 64;
  localparam int DEF_BLOCK_BITS  = 32;
  localparam int TOTAL_W         = 39;
  localparam int CHAIN_CFG_W     = 3;
  localparam int TSEL_W          = 2;
  localparam int STEP_W          = 8;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_GOTO  = 2'd1,
    ACT_NEXT  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ROP_IDLE,
    ROP_CMP,
    ROP_FLAG,
    ROP_ADD,
    ROP_START,
    ROP_CLEAR,
    ROP_STEP,
    ROP_ADVANCE
  } row_op_t;

  typedef struct packed {
    logic lt;
    logic adj;
    logic fe;
  } cell_flags_t;

  typedef struct packed {
    logic ext;
    logic absorb;
    logic full;
  } add_plan_t;

  typedef struct packed {
    logic live;
    logic moved;
    logic add_full;
    logic nonempty;
  } row_stat_t;

endpackage
`default_nettype wire

FILE: src/etbw_cell.sv
`default_nettype none
module etbw_cell #(
  parameter int BLOCK_BITS = etbw_pkg::DEF_BLOCK_BITS,
  parameter bit IS_HEAD    = 1'b0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  etbw_pkg::row_op_t      op,
  input  logic                   valid,
  input  logic [BLOCK_BITS-1:0]  s,
  input  logic [BLOCK_BITS-1:0]  e,
  input  logic [BLOCK_BITS-1:0]  s_dec,
  input  logic [BLOCK_BITS-1:0]  e_inc,
  input  etbw_pkg::add_plan_t    plan,
  input  logic [BLOCK_BITS-1:0]  prev_first,
  input  logic [BLOCK_BITS-1:0]  prev_last,
  input  logic                   prev_mark,
  input  logic                   prev_lt,
  input  logic [BLOCK_BITS-1:0]  next_first,
  input  logic [BLOCK_BITS-1:0]  next_last,
  input  logic                   next_mark,
  input  logic                   next_lt,
  output logic [BLOCK_BITS-1:0]  first,
  output logic [BLOCK_BITS-1:0]  last,
  output logic                   mark,
  output etbw_pkg::cell_flags_t  flags
);

  logic pred;

  // last extent below the new start
  assign pred = flags.lt && !next_lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark  <= 1'b0;
      flags <= '0;
    end else begin
      case (op)
        etbw_pkg::ROP_CMP: begin
          flags.lt  <= valid && (first < s);
          flags.adj <= valid && (last == s_dec);
          flags.fe  <= valid && (first == e_inc);
        end
        etbw_pkg::ROP_ADD: begin
          if (plan.ext) begin
            if (pred) begin
              if (plan.absorb) mark <= mark | next_mark;
            end else if (plan.absorb && !flags.lt) begin
              mark <= next_mark;
            end
          end else if (!plan.full && !flags.lt) begin
            mark <= prev_lt ? 1'b0 : prev_mark;
          end
        end
        etbw_pkg::ROP_START:   mark <= IS_HEAD;
        etbw_pkg::ROP_ADVANCE: mark <= prev_mark;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == etbw_pkg::ROP_ADD) begin
      if (plan.ext) begin
        if (pred) begin
          last <= plan.absorb ? next_last : e;
        end else if (plan.absorb && !flags.lt) begin
          first <= next_first;
          last  <= next_last;
        end
      end else if (!plan.full && !flags.lt) begin
        if (prev_lt) begin
          first <= s;
          last  <= e;
        end else begin
          first <= prev_first;
          last  <= prev_last;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/etbw_row.sv
`default_nettype none
module etbw_row #(
  parameter int MAX_EXTENTS = etbw_pkg::DEF_MAX_EXTENTS,
  parameter int BLOCK_BITS  = etbw_pkg::DEF_BLOCK_BITS,
  parameter int CW          = $clog2(MAX_EXTENTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  etbw_pkg::row_op_t             op,
  input  logic [BLOCK_BITS-1:0]         s,
  input  logic [BLOCK_BITS-1:0]         e,
  output logic [CW-1:0]                 count,
  output logic [etbw_pkg::TOTAL_W-1:0]  total,
  output logic [BLOCK_BITS-1:0]         block,
  output etbw_pkg::row_stat_t           stat
);

  localparam int N     = MAX_EXTENTS;
  localparam int SUM_W = (BLOCK_BITS + 1 > etbw_pkg::TOTAL_W) ? BLOCK_BITS + 1
                                                               : etbw_pkg::TOTAL_W;

  logic [BLOCK_BITS-1:0]  first_x [0:N+1];
  logic [BLOCK_BITS-1:0]  last_x  [0:N+1];
  logic                   mark_x  [0:N+1];
  logic                   lt_x    [0:N+1];
  logic                   fe_x    [0:N+1];
  logic                   adj_v   [0:N-1];
  logic                   valid_v [0:N-1];
  etbw_pkg::cell_flags_t  flags_v [0:N-1];

  logic [BLOCK_BITS-1:0]  s_dec, e_inc;
  logic [BLOCK_BITS:0]    len_r;
  logic [SUM_W-1:0]       sum;
  etbw_pkg::add_plan_t    plan;
  etbw_pkg::row_op_t      cell_op;
  logic                   live, moved, ext_c, fe_c;
  logic [BLOCK_BITS-1:0]  sel_last, sel_nfirst, sel_last_c, sel_nfirst_c;
  logic                   sel_hasnext, sel_hasnext_c;

  assign s_dec = s - BLOCK_BITS'(1);
  assign e_inc = e + BLOCK_BITS'(1);
  assign sum   = SUM_W'(total) + SUM_W'(len_r);
  assign moved = live && (block == sel_last) && sel_hasnext;
  assign cell_op = (op == etbw_pkg::ROP_STEP) ? (moved ? etbw_pkg::ROP_ADVANCE
                                                       : etbw_pkg::ROP_IDLE) : op;

  // chain ends: everything before the head counts as below the start
  assign first_x[0]   = '0;
  assign last_x[0]    = '0;
  assign mark_x[0]    = 1'b0;
  assign lt_x[0]      = 1'b1;
  assign fe_x[0]      = 1'b0;
  assign first_x[N+1] = '0;
  assign last_x[N+1]  = '0;
  assign mark_x[N+1]  = 1'b0;
  assign lt_x[N+1]    = 1'b0;
  assign fe_x[N+1]    = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign valid_v[i]  = count > CW'(i);
    assign lt_x[i+1]   = flags_v[i].lt;
    assign fe_x[i+1]   = flags_v[i].fe;
    assign adj_v[i]    = flags_v[i].adj;

    etbw_cell #(
      .BLOCK_BITS (BLOCK_BITS),
      .IS_HEAD    (i == 0)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (cell_op),
      .valid      (valid_v[i]),
      .s          (s),
      .e          (e),
      .s_dec      (s_dec),
      .e_inc      (e_inc),
      .plan       (plan),
      .prev_first (first_x[i]),
      .prev_last  (last_x[i]),
      .prev_mark  (mark_x[i]),
      .prev_lt    (lt_x[i]),
      .next_first (first_x[i+2]),
      .next_last  (last_x[i+2]),
      .next_mark  (mark_x[i+2]),
      .next_lt    (lt_x[i+2]),
      .first      (first_x[i+1]),
      .last       (last_x[i+1]),
      .mark       (mark_x[i+1]),
      .flags      (flags_v[i])
    );
  end

  // merge decision and cursor neighborhood, both reduced across the row
  always_comb begin
    ext_c         = 1'b0;
    fe_c          = 1'b0;
    sel_last_c    = '0;
    sel_nfirst_c  = '0;
    sel_hasnext_c = 1'b0;
    for (int i = 0; i < N; i++) begin
      ext_c         = ext_c | (lt_x[i+1] & ~lt_x[i+2] & adj_v[i]);
      fe_c          = fe_c | (lt_x[i+1] & ~lt_x[i+2] & fe_x[i+2]);
      sel_last_c    = sel_last_c | ({BLOCK_BITS{mark_x[i+1]}} & last_x[i+1]);
      sel_nfirst_c  = sel_nfirst_c | ({BLOCK_BITS{mark_x[i]}} & first_x[i+1]);
      sel_hasnext_c = sel_hasnext_c | (mark_x[i] & valid_v[i]);
    end
  end

  always_ff @(posedge clk) begin
    sel_last    <= sel_last_c;
    sel_nfirst  <= sel_nfirst_c;
    sel_hasnext <= sel_hasnext_c;
    if (op == etbw_pkg::ROP_CMP) len_r <= {1'b0, e - s} + (BLOCK_BITS + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
      live  <= 1'b0;
      block <= '0;
      plan  <= '0;
    end else begin
      case (op)
        etbw_pkg::ROP_FLAG: begin
          plan.ext    <= ext_c;
          plan.absorb <= ext_c && fe_c;
          plan.full   <= count == CW'(MAX_EXTENTS);
        end
        etbw_pkg::ROP_ADD: begin
          if (plan.ext) begin
            total <= sum[etbw_pkg::TOTAL_W-1:0];
            if (plan.absorb) count <= count - CW'(1);
          end else if (!plan.full) begin
            total <= sum[etbw_pkg::TOTAL_W-1:0];
            count <= count + CW'(1);
          end
        end
        etbw_pkg::ROP_START: begin
          live <= count != '0;
          if (count != '0) block <= first_x[1];
        end
        etbw_pkg::ROP_CLEAR: begin
          count <= '0;
          total <= '0;
          live  <= 1'b0;
        end
        etbw_pkg::ROP_STEP: begin
          if (live) begin
            if (block == sel_last) begin
              if (sel_hasnext) begin
                block <= sel_nfirst;
              end else begin
                live  <= 1'b0;
                block <= '0;
              end
            end else begin
              block <= block + BLOCK_BITS'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.live     = live;
  assign stat.moved    = moved;
  assign stat.add_full = !plan.ext && plan.full;
  assign stat.nonempty = count != '0;

endmodule
`default_nettype wire

FILE: src/extent_table_block_walker_core.sv
// From request to done: add runs the compare, flag and apply phases; goto and
// clear run one phase each; next runs a step phase per step, with a fetch phase
// at each extent boundary crossed, then a seek and a search over up to MAX_CHAINS tables.
// One request at a time; busy is high until done. The receiver cannot stall:
// done and the result ports are valid for one cycle.
// rst (synchronous) empties every table, drops all cursors, sets chain_count 1.
`default_nettype none
module extent_table_block_walker_core #(
  parameter int MAX_CHAINS  = etbw_pkg::DEF_MAX_CHAINS,
  parameter int MAX_EXTENTS = etbw_pkg::DEF_MAX_EXTENTS,
  parameter int BLOCK_BITS  = etbw_pkg::DEF_BLOCK_BITS,
  parameter int CW          = $clog2(MAX_EXTENTS + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        action,
  input  logic [etbw_pkg::TSEL_W-1:0]       table_select,
  input  logic [BLOCK_BITS-1:0]             start_block,
  input  logic [BLOCK_BITS-1:0]             end_block,
  input  logic [etbw_pkg::STEP_W-1:0]       step_count,
  input  logic                              stripe,
  input  logic                              cfg_we,
  input  logic [etbw_pkg::CHAIN_CFG_W-1:0]  cfg_wdata,
  output logic                              done,
  output logic                              status,
  output logic [BLOCK_BITS-1:0]             next_block,
  output logic [CW-1:0]                     table_extents,
  output logic [etbw_pkg::TOTAL_W-1:0]      table_blocks
);

  localparam int ACT_W = $clog2(MAX_CHAINS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_CMP, S_ADD_FLAG, S_ADD_APPLY, S_CLEAR, S_GOTO,
    S_FETCH, S_RUN, S_SEEK, S_STRIPE, S_SEQ, S_FINISH
  } state_t;

  state_t                               state;
  etbw_pkg::action_t                    action_r;
  logic [etbw_pkg::TSEL_W-1:0]          tsel_r;
  logic [BLOCK_BITS-1:0]                s_r, e_r;
  logic [etbw_pkg::STEP_W-1:0]          steps_r;
  logic                                 stripe_r;
  logic [etbw_pkg::CHAIN_CFG_W-1:0]     chain_count;
  logic [ACT_W-1:0]                     active, origin, n_used, act_inc, stripe_cand;

  etbw_pkg::row_op_t                    op_v    [0:MAX_CHAINS-1];
  logic [CW-1:0]                        count_v [0:MAX_CHAINS-1];
  logic [etbw_pkg::TOTAL_W-1:0]         total_v [0:MAX_CHAINS-1];
  logic [BLOCK_BITS-1:0]                block_v [0:MAX_CHAINS-1];
  etbw_pkg::row_stat_t                  stat_v  [0:MAX_CHAINS-1];

  logic                                 tsel_ok, act_live, act_moved, cand_nz, cand_live;
  logic                                 sel_full;
  logic [BLOCK_BITS-1:0]                act_block;
  logic [CW-1:0]                        sel_count;
  logic [etbw_pkg::TOTAL_W-1:0]         sel_total;

  assign busy    = state != S_IDLE;
  assign tsel_ok = int'(tsel_r) < MAX_CHAINS;
  assign act_inc = active + ACT_W'(1);
  assign stripe_cand = (act_inc >= n_used) ? '0 : act_inc;

  // chain counts above the number of tables act as the full set
  always_comb begin
    if (4'(chain_count) > 4'(MAX_CHAINS)) n_used = ACT_W'(MAX_CHAINS);
    else n_used = ACT_W'(chain_count);
  end

  // pick out the active table, the search candidate and the reported table
  always_comb begin
    act_live  = 1'b0;
    act_moved = 1'b0;
    act_block = '0;
    cand_nz   = 1'b0;
    cand_live = 1'b0;
    sel_full  = 1'b0;
    sel_count = '0;
    sel_total = '0;
    for (int t = 0; t < MAX_CHAINS; t++) begin
      if (int'(active) == t) begin
        act_live  = stat_v[t].live;
        act_moved = stat_v[t].moved;
        act_block = block_v[t];
      end
      if (int'(act_inc) == t) cand_nz = stat_v[t].nonempty;
      if (int'(stripe_cand) == t) cand_live = stat_v[t].live;
      if (int'(tsel_r) == t) begin
        sel_full  = stat_v[t].add_full;
        sel_count = count_v[t];
        sel_total = total_v[t];
      end
    end
  end

  // drive each table's row with the operation of the current phase
  always_comb begin
    for (int t = 0; t < MAX_CHAINS; t++) begin
      op_v[t] = etbw_pkg::ROP_IDLE;
      case (state)
        S_ADD_CMP:   if (int'(tsel_r) == t) op_v[t] = etbw_pkg::ROP_CMP;
        S_ADD_FLAG:  if (int'(tsel_r) == t) op_v[t] = etbw_pkg::ROP_FLAG;
        S_ADD_APPLY: if (int'(tsel_r) == t) op_v[t] = etbw_pkg::ROP_ADD;
        S_CLEAR:     if (int'(tsel_r) == t) op_v[t] = etbw_pkg::ROP_CLEAR;
        S_GOTO:      if (t < int'(n_used)) op_v[t] = etbw_pkg::ROP_START;
        S_RUN:       if (int'(active) == t) op_v[t] = etbw_pkg::ROP_STEP;
        S_SEQ: begin
          if (int'(act_inc) == t && act_inc < n_used && cand_nz)
            op_v[t] = etbw_pkg::ROP_START;
        end
        default: ;
      endcase
    end
  end

  for (genvar t = 0; t < MAX_CHAINS; t++) begin : g_row
    etbw_row #(
      .MAX_EXTENTS (MAX_EXTENTS),
      .BLOCK_BITS  (BLOCK_BITS),
      .CW          (CW)
    ) u_row (
      .clk   (clk),
      .rst   (rst),
      .op    (op_v[t]),
      .s     (s_r),
      .e     (e_r),
      .count (count_v[t]),
      .total (total_v[t]),
      .block (block_v[t]),
      .stat  (stat_v[t])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      active      <= '0;
      chain_count <= etbw_pkg::CHAIN_CFG_W'(1);
    end else begin
      done <= 1'b0;
      if (cfg_we) chain_count <= cfg_wdata;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            action_r <= etbw_pkg::action_t'(action);
            tsel_r   <= table_select;
            s_r      <= start_block;
            e_r      <= end_block;
            steps_r  <= step_count;
            stripe_r <= stripe;
            unique case (etbw_pkg::action_t'(action))
              etbw_pkg::ACT_ADD:
                state <= (int'(table_select) < MAX_CHAINS) ? S_ADD_CMP : S_FINISH;
              etbw_pkg::ACT_GOTO: state <= S_GOTO;
              etbw_pkg::ACT_NEXT: begin
                // a walk already past the last table reports zero
                if (active >= n_used) state <= S_FINISH;
                else if (step_count == '0) state <= S_SEEK;
                else state <= S_FETCH;
              end
              etbw_pkg::ACT_CLEAR:
                state <= (int'(table_select) < MAX_CHAINS) ? S_CLEAR : S_FINISH;
              default: state <= S_FINISH;
            endcase
          end
        end
        S_ADD_CMP:   state <= S_ADD_FLAG;
        S_ADD_FLAG:  state <= S_ADD_APPLY;
        S_ADD_APPLY: state <= S_FINISH;
        S_CLEAR:     state <= S_FINISH;
        S_GOTO: begin
          active <= '0;
          state  <= S_FINISH;
        end
        // let the row's cursor neighborhood settle after the cursor moved
        S_FETCH: state <= S_RUN;
        S_RUN: begin
          steps_r <= steps_r - etbw_pkg::STEP_W'(1);
          if (steps_r == etbw_pkg::STEP_W'(1) || !act_live) state <= S_SEEK;
          else if (act_moved) state <= S_FETCH;
        end
        S_SEEK: begin
          if (stripe_r) begin
            origin <= active;
            state  <= S_STRIPE;
          end else if (act_live) begin
            state <= S_FINISH;
          end else begin
            state <= S_SEQ;
          end
        end
        // round-robin: advance to the next live table, stop back at the origin
        S_STRIPE: begin
          active <= stripe_cand;
          if (stripe_cand == origin || cand_live) state <= S_FINISH;
        end
        // sequential: advance to the next non-empty table and load its cursor
        S_SEQ: begin
          active <= act_inc;
          if (act_inc >= n_used || cand_nz) state <= S_FINISH;
        end
        S_FINISH: begin
          done          <= 1'b1;
          status        <= (action_r == etbw_pkg::ACT_ADD) && tsel_ok && sel_full;
          next_block    <= (action_r == etbw_pkg::ACT_NEXT && active < n_used)
                           ? act_block : '0;
          table_extents <= tsel_ok ? sel_count : '0;
          table_blocks  <= tsel_ok ? sel_total : '0;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/etbw_checker.sv
`default_nettype none
`include "assert_macros.svh"
module etbw_checker #(
  parameter int BLOCK_BITS = etbw_pkg::DEF_BLOCK_BITS
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic                  status,
  input logic [BLOCK_BITS-1:0] next_block
);

  `ETBW_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "request not taken up")
  `ETBW_ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy, "done while still busy")
  `ETBW_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "done held past one cycle")
  `ETBW_ASSERT_IMPLY(a_full_no_walk, clk, rst, done && status, next_block == '0, "full with a block")

endmodule

bind extent_table_block_walker_core etbw_checker #(
  .BLOCK_BITS (BLOCK_BITS)
) u_etbw_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .next_block (next_block)
);
`default_nettype wire

FILE: bench/extent_table_block_walker_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module extent_table_block_walker_core_tb;
  import etbw_pkg::*;

  localparam int NT = DEF_MAX_CHAINS;
  localparam int NE = DEF_MAX_EXTENTS;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    action_t     act;
    logic [1:0]  tsel;
    logic [31:0] sb;
    logic [31:0] eb;
    logic [7:0]  steps;
    logic        str;
  } request_t;

  typedef struct {
    logic        status;
    logic [31:0] reached;
    logic [6:0]  extents;
    logic [38:0] blocks;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] action = '0;
  logic [1:0] table_select = '0;
  logic [31:0] start_block = '0;
  logic [31:0] end_block = '0;
  logic [7:0] step_count = '0;
  logic stripe = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_wdata = '0;
  wire busy, done, status;
  wire [31:0] next_block;
  wire [6:0] table_extents;
  wire [38:0] table_blocks;

  extent_table_block_walker_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .table_select(table_select),
    .start_block(start_block), .end_block(end_block),
    .step_count(step_count), .stripe(stripe),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .status(status), .next_block(next_block),
    .table_extents(table_extents), .table_blocks(table_blocks)
  );

  // Shadow copy of the block's tables and walker.
  logic [31:0] ext_first [NT][NE];
  logic [31:0] ext_last [NT][NE];
  int          ext_cnt [NT];
  logic [38:0] blk_sum [NT];
  int          cur_entry [NT];
  bit          cur_live [NT];
  logic [31:0] cur_block [NT];
  int          walk_tbl;
  int          chain_setting;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  request_t cur_req;
  int sender_idle_pct = 37;
  bit hold_off = 1'b0;
  int errors = 0;
  int stall_cycles = 0;
  logic [31:0] last_end [NT];

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int t = 0; t < NT; t++) begin
      ext_cnt[t] = 0; blk_sum[t] = '0; cur_entry[t] = 0;
      cur_live[t] = 1'b0; cur_block[t] = '0; last_end[t] = 32'd100;
    end
    walk_tbl = 0;
    chain_setting = 1;
  end

  function automatic int chains_walked();
    return (chain_setting > NT) ? NT : chain_setting;
  endfunction

  function automatic logic insert_range(int t, logic [31:0] s, logic [31:0] e);
    int n;
    int p;
    logic [38:0] len;
    n = ext_cnt[t];
    p = 0;
    len = {7'd0, e - s} + 39'd1;
    while (p < n && ext_first[t][p] < s) p++;
    // Extend the previous extent when the new range continues it.
    if (p > 0 && ext_last[t][p-1] == s - 32'd1) begin
      ext_last[t][p-1] = e;
      if (p < n && e + 32'd1 == ext_first[t][p]) begin
        // Absorb the following extent and close the gap it leaves.
        ext_last[t][p-1] = ext_last[t][p];
        for (int i = p; i < n - 1; i++) begin
          ext_first[t][i] = ext_first[t][i+1];
          ext_last[t][i] = ext_last[t][i+1];
        end
        ext_cnt[t] = n - 1;
        if (cur_live[t] && cur_entry[t] >= p) cur_entry[t]--;
      end
      blk_sum[t] = blk_sum[t] + len;
      return 1'b0;
    end
    if (n >= NE) return 1'b1;
    for (int i = n; i > p; i--) begin
      ext_first[t][i] = ext_first[t][i-1];
      ext_last[t][i] = ext_last[t][i-1];
    end
    ext_first[t][p] = s;
    ext_last[t][p] = e;
    ext_cnt[t] = n + 1;
    if (cur_live[t] && cur_entry[t] >= p) cur_entry[t]++;
    blk_sum[t] = blk_sum[t] + len;
    return 1'b0;
  endfunction

  function automatic void advance_cursor(int t);
    int k;
    if (!cur_live[t] || cur_entry[t] >= ext_cnt[t]) begin
      cur_live[t] = 1'b0;
      return;
    end
    k = cur_entry[t];
    if (cur_block[t] == ext_last[t][k]) begin
      if (k + 1 < ext_cnt[t]) begin
        cur_entry[t] = k + 1;
        cur_block[t] = ext_first[t][k+1];
      end else begin
        cur_live[t] = 1'b0;
        cur_block[t] = '0;
      end
    end else begin
      cur_block[t] = cur_block[t] + 32'd1;
    end
  endfunction

  function automatic logic [31:0] walk_blocks(int steps, bit str);
    int n;
    int origin;
    n = chains_walked();
    if (walk_tbl >= n) return '0;
    for (int i = 0; i < steps; i++) advance_cursor(walk_tbl);
    if (str) begin
      // Round-robin: move to the next live table, or stay if none.
      origin = walk_tbl;
      forever begin
        walk_tbl++;
        if (walk_tbl >= n) walk_tbl = 0;
        if (walk_tbl == origin || cur_live[walk_tbl]) break;
      end
    end else begin
      while (!cur_live[walk_tbl]) begin
        walk_tbl++;
        if (walk_tbl >= n) break;
        if (ext_cnt[walk_tbl] > 0) begin
          cur_live[walk_tbl] = 1'b1;
          cur_entry[walk_tbl] = 0;
          cur_block[walk_tbl] = ext_first[walk_tbl][0];
        end
      end
    end
    if (walk_tbl >= n) return '0;
    return cur_block[walk_tbl];
  endfunction

  function automatic outcome_t predict_outcome(request_t r);
    outcome_t o;
    int t;
    t = r.tsel;
    o.status = 1'b0;
    o.reached = '0;
    case (r.act)
      ACT_ADD: o.status = insert_range(t, r.sb, r.eb);
      ACT_GOTO: begin
        for (int i = 0; i < chains_walked(); i++) begin
          cur_entry[i] = 0;
          cur_live[i] = ext_cnt[i] > 0;
          if (cur_live[i]) cur_block[i] = ext_first[i][0];
        end
        walk_tbl = 0;
      end
      ACT_NEXT: o.reached = walk_blocks(r.steps, r.str);
      default: begin
        ext_cnt[t] = 0; blk_sum[t] = '0;
        cur_live[t] = 1'b0; cur_entry[t] = 0;
      end
    endcase
    o.extents = ext_cnt[t][6:0];
    o.blocks = blk_sum[t];
    return o;
  endfunction

  task automatic queue_request(action_t a, int t, logic [31:0] s, logic [31:0] e,
                               int st, bit str);
    request_t r;
    r.act = a; r.tsel = t[1:0]; r.sb = s; r.eb = e; r.steps = st[7:0]; r.str = str;
    pending_reqs.push_back(r);
  endtask

  // Mostly small, clustered ranges so extends and merges happen often.
  task automatic queue_random();
    int pick;
    int t;
    logic [31:0] s;
    logic [31:0] e;
    pick = $urandom_range(99);
    t = $urandom_range(3);
    if (pick < 45) begin
      case ($urandom_range(5))
        0: begin s = $urandom; e = $urandom; end
        1, 2: begin s = last_end[t] + 32'd1; e = s + $urandom_range(4); end
        default: begin s = $urandom_range(400); e = s + $urandom_range(6); end
      endcase
      last_end[t] = e;
      queue_request(ACT_ADD, t, s, e, $urandom_range(255), $urandom_range(1));
    end else if (pick < 82) begin
      queue_request(ACT_NEXT, t, $urandom, $urandom,
                    ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(6),
                    $urandom_range(1));
    end else if (pick < 94) begin
      queue_request(ACT_GOTO, t, $urandom, $urandom, $urandom_range(255), $urandom_range(1));
    end else begin
      queue_request(ACT_CLEAR, t, $urandom, $urandom, $urandom_range(255),
                    $urandom_range(1));
    end
  endtask

  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || start || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_chains(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[2:0];
    chain_setting = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: hold a request until accepted, then predict it and present the next one.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_outcomes.push_back(predict_outcome(cur_req));
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && !hold_off &&
            $urandom_range(99) >= sender_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          action <= cur_req.act;
          table_select <= cur_req.tsel;
          start_block <= cur_req.sb;
          end_block <= cur_req.eb;
          step_count <= cur_req.steps;
          stripe <= cur_req.str;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    outcome_t x;
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        errors++;
      end else begin
        x = expected_outcomes.pop_front();
        if (status !== x.status) begin
          $display("%0t: status expected %0d got %0d", $time, x.status, status);
          errors++;
        end
        if (next_block !== x.reached) begin
          $display("%0t: next_block expected %0h got %0h", $time, x.reached, next_block);
          errors++;
        end
        if (table_extents !== x.extents) begin
          $display("%0t: table_extents expected %0d got %0d", $time, x.extents,
                   table_extents);
          errors++;
        end
        if (table_blocks !== x.blocks) begin
          $display("%0t: table_blocks expected %0h got %0h", $time, x.blocks,
                   table_blocks);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("extent_table_block_walker_core verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_chains(4);

    // Directed: extend, extend with absorb, wrap at the top, reversed range.
    queue_request(ACT_ADD, 0, 32'd10, 32'd20, 0, 0);
    queue_request(ACT_ADD, 0, 32'd21, 32'd30, 0, 0);
    queue_request(ACT_ADD, 0, 32'd40, 32'd50, 0, 0);
    queue_request(ACT_ADD, 0, 32'd31, 32'd39, 0, 0);
    queue_request(ACT_ADD, 1, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 255, 1);
    queue_request(ACT_ADD, 2, 32'd100, 32'd5, 0, 0);
    queue_request(ACT_ADD, 2, 32'd0, 32'd0, 0, 0);
    queue_request(ACT_GOTO, 0, 0, 0, 0, 0);
    queue_request(ACT_NEXT, 0, 0, 0, 0, 0);
    queue_request(ACT_NEXT, 0, 0, 0, 1, 0);
    queue_request(ACT_NEXT, 0, 0, 0, 255, 1);
    queue_request(ACT_ADD, 0, 32'd0, 32'd2, 0, 0);
    queue_request(ACT_NEXT, 1, 0, 0, 40, 0);
    queue_request(ACT_NEXT, 2, 0, 0, 20, 1);
    queue_request(ACT_CLEAR, 0, 0, 0, 0, 0);
    queue_request(ACT_NEXT, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 255, 1);
    // Fill table 3 past capacity, then extend while full, then empty it.
    for (int i = 0; i < NE + 1; i++)
      queue_request(ACT_ADD, 3, i * 10, i * 10 + 1, 0, 0);
    queue_request(ACT_ADD, 3, 32'd2, 32'd3, 0, 0);
    queue_request(ACT_CLEAR, 3, 0, 0, 0, 0);

    // Wait for every outstanding result before the random part.
    wait_quiet();
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) queue_random();
    hold_off = 1'b0;
    wait (pending_reqs.size() == 0);
    hold_off = 1'b1;
    while (expected_outcomes.size() != 0 || start) @(posedge clk);
    hold_off = 1'b0;
    for (int i = 0; i < 50; i++) queue_random();
    wait_quiet();

    set_chains(2);
    sender_idle_pct = 58;
    for (int i = 0; i < 150; i++) queue_random();
    wait_quiet();

    set_chains(7);
    sender_idle_pct = 0;
    for (int i = 0; i < 80; i++) queue_random();
    wait_quiet();
    set_chains(0);
    for (int i = 0; i < 30; i++) queue_random();
    wait_quiet();
    set_chains(1);
    for (int i = 0; i < 40; i++) queue_random();
    wait_quiet();

    repeat (50) @(posedge clk);
    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("extent_table_block_walker_core verification clean");
    end else begin
      $display("extent_table_block_walker_core verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
